FILE: hw/rtl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// shared types, codes and helpers of the maze wall map
// ----------------------------------------------------------------------------
package mwm_pkg;

	localparam int MAZE_DIM_DEF = 8;
	localparam int COORD_W = 6;

	typedef logic [1:0] mark_t;
	localparam mark_t MARK_OPEN = 2'd0;
	localparam mark_t MARK_WALL = 2'd1;
	localparam mark_t MARK_UNKNOWN = 2'd2;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_DOWN = 2'd1,
		DIR_LEFT = 2'd2,
		DIR_UP = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		SIDE_LEFT = 2'd0,
		SIDE_FRONT = 2'd1,
		SIDE_RIGHT = 2'd2,
		SIDE_BEHIND = 2'd3
	} side_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD0,
		S_RD1,
		S_WR0,
		S_WR1,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic rd0;
		logic rd1;
		logic wr0;
		logic wr1;
		logic done;
	} mwm_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} mwm_sts_t;

	// which sensor looks at a wall in a given direction for a given heading
	function automatic side_t side_of(input dir_t dir, input logic [1:0] hd);
		logic [1:0] d;
		d = 2'(dir);
		return side_t'(2'(d - hd + 2'd1));
	endfunction

	function automatic mark_t sensed_mark(input logic [2:0] seen, input side_t side);
		mark_t m;
		case (side)
			SIDE_LEFT: m = seen[0] ? MARK_WALL : MARK_OPEN;
			SIDE_FRONT: m = seen[1] ? MARK_WALL : MARK_OPEN;
			SIDE_RIGHT: m = seen[2] ? MARK_WALL : MARK_OPEN;
			default: m = MARK_UNKNOWN;
		endcase
		return m;
	endfunction

endpackage

FILE: hw/rtl/mwm_ctrl.sv
// ----------------------------------------------------------------------------
// mwm_ctrl
// sequencer: clearing pass after reset, then read, write and report steps
// ----------------------------------------------------------------------------
module mwm_ctrl
	import mwm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  mwm_sts_t sts,
	output mwm_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		item_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d = S_RD0;
				end
			end
			S_RD0: begin
				cmd.rd0 = 1'b1;
				state_d = S_RD1;
			end
			S_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = S_WR0;
			end
			S_WR0: begin
				cmd.wr0 = 1'b1;
				state_d = S_WR1;
			end
			S_WR1: begin
				cmd.wr1 = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_clear_runs: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR && !sts.clr_last |=> state_q == S_CLEAR)
		else $error("clearing pass left early");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one command at once");

	a_wr_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr0 |=> cmd.wr1)
		else $error("second write step missing");

endmodule

FILE: hw/rtl/mwm_dp.sv
// ----------------------------------------------------------------------------
// mwm_dp
// map memories, item registers, wall merge and result register
// ----------------------------------------------------------------------------
module mwm_dp
	import mwm_pkg::*;
#(
	parameter int MAZE_DIM = MAZE_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  mwm_cmd_t   cmd,
	output mwm_sts_t   sts,
	input  logic       req_type,
	input  logic [2:0] row,
	input  logic [2:0] col,
	input  logic [1:0] heading,
	input  logic [2:0] walls_seen,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       open_right,
	output logic       open_left,
	output logic       open_down,
	output logic       open_up,
	output logic       cell_visited,
	output logic       at_goal
);

	localparam int CELLS = MAZE_DIM * MAZE_DIM;
	localparam int AW = $clog2(CELLS);
	localparam int GOAL_HI = MAZE_DIM / 2;
	localparam int GOAL_LO = GOAL_HI - 1;

	mark_t vert_mem [CELLS];
	mark_t horiz_mem [CELLS];
	logic  vis_mem [CELLS];

	logic          req_q;
	logic [2:0]    row_q;
	logic [2:0]    col_q;
	logic [1:0]    hd_q;
	logic [2:0]    seen_q;
	logic [AW-1:0] clr_q;
	mark_t         vert_rd_q;
	mark_t         horiz_rd_q;
	logic          vis_rd_q;
	mark_t         mr_q;
	mark_t         md_q;
	mark_t         ml_q;
	mark_t         mu_q;
	logic          vis_q;
	logic          result_valid_q;
	logic          open_right_q;
	logic          open_left_q;
	logic          open_down_q;
	logic          open_up_q;
	logic          cell_visited_q;
	logic          at_goal_q;

	logic [COORD_W-1:0] row_x;
	logic [COORD_W-1:0] col_x;
	logic          in_map;
	logic          in_r;
	logic          in_l;
	logic          in_d;
	logic          in_u;
	logic          upd;
	logic          goal;
	logic [AW-1:0] idx_c;
	logic [AW-1:0] idx_l;
	logic [AW-1:0] idx_u;
	side_t         side_r;
	side_t         side_l;
	side_t         side_d;
	side_t         side_u;
	logic          we_r;
	logic          we_l;
	logic          we_d;
	logic          we_u;
	mark_t         eff_r;
	mark_t         eff_l;
	mark_t         eff_d;
	mark_t         eff_u;
	logic [AW-1:0] vert_ra;
	logic [AW-1:0] horiz_ra;
	logic          vert_we;
	logic          horiz_we;
	logic          vis_we;
	logic [AW-1:0] vert_wa;
	logic [AW-1:0] horiz_wa;
	mark_t         vert_wd;
	mark_t         horiz_wd;
	logic          vis_wd;

	// item fields and cell geometry
	always_comb begin
		row_x = COORD_W'(row_q);
		col_x = COORD_W'(col_q);
		in_map = (row_x < COORD_W'(MAZE_DIM)) && (col_x < COORD_W'(MAZE_DIM));
		in_r = col_x < COORD_W'(MAZE_DIM - 1);
		in_l = col_q != 3'd0;
		in_d = row_x < COORD_W'(MAZE_DIM - 1);
		in_u = row_q != 3'd0;
		upd = !req_q && in_map;
		goal = (row_x == COORD_W'(GOAL_HI) || row_x == COORD_W'(GOAL_LO)) &&
			(col_x == COORD_W'(GOAL_HI) || col_x == COORD_W'(GOAL_LO));
		idx_c = AW'(int'(row_q) * MAZE_DIM + int'(col_q));
		idx_l = idx_c - AW'(1);
		idx_u = idx_c - AW'(MAZE_DIM);
		side_r = side_of(DIR_RIGHT, hd_q);
		side_l = side_of(DIR_LEFT, hd_q);
		side_d = side_of(DIR_DOWN, hd_q);
		side_u = side_of(DIR_UP, hd_q);
		we_r = upd && in_r && (side_r != SIDE_BEHIND);
		we_l = upd && in_l && (side_l != SIDE_BEHIND);
		we_d = upd && in_d && (side_d != SIDE_BEHIND);
		we_u = upd && in_u && (side_u != SIDE_BEHIND);
		eff_r = we_r ? sensed_mark(seen_q, side_r) : mr_q;
		eff_l = we_l ? sensed_mark(seen_q, side_l) : ml_q;
		eff_d = we_d ? sensed_mark(seen_q, side_d) : md_q;
		eff_u = we_u ? sensed_mark(seen_q, side_u) : mu_q;
	end

	// memory port steering
	always_comb begin
		vert_ra = cmd.rd1 ? idx_l : idx_c;
		horiz_ra = cmd.rd1 ? idx_u : idx_c;
		vert_we = 1'b0;
		horiz_we = 1'b0;
		vis_we = 1'b0;
		vert_wa = idx_c;
		horiz_wa = idx_c;
		vert_wd = MARK_UNKNOWN;
		horiz_wd = MARK_UNKNOWN;
		vis_wd = 1'b1;
		if (cmd.clear) begin
			vert_we = 1'b1;
			horiz_we = 1'b1;
			vis_we = 1'b1;
			vert_wa = clr_q;
			horiz_wa = clr_q;
			vis_wd = 1'b0;
		end else if (cmd.wr0) begin
			vert_we = we_r;
			horiz_we = we_d;
			vis_we = upd;
			vert_wd = eff_r;
			horiz_wd = eff_d;
		end else if (cmd.wr1) begin
			vert_we = we_l;
			horiz_we = we_u;
			vert_wa = idx_l;
			horiz_wa = idx_u;
			vert_wd = eff_l;
			horiz_wd = eff_u;
		end
	end

	always_ff @(posedge clk) begin
		if (vert_we) begin
			vert_mem[vert_wa] <= vert_wd;
		end
		if (horiz_we) begin
			horiz_mem[horiz_wa] <= horiz_wd;
		end
		if (vis_we) begin
			vis_mem[cmd.clear ? clr_q : idx_c] <= vis_wd;
		end
		vert_rd_q <= vert_mem[vert_ra];
		horiz_rd_q <= horiz_mem[horiz_ra];
		vis_rd_q <= vis_mem[idx_c];
	end

	// item word and captured marks
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_type;
			row_q <= row;
			col_q <= col;
			hd_q <= heading;
			seen_q <= walls_seen;
		end
		if (cmd.rd1) begin
			mr_q <= vert_rd_q;
			md_q <= horiz_rd_q;
			vis_q <= vis_rd_q;
		end
		if (cmd.wr0) begin
			ml_q <= vert_rd_q;
			mu_q <= horiz_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= sts.clr_last ? '0 : clr_q + AW'(1);
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			open_right_q <= in_map && in_r && (eff_r == MARK_OPEN);
			open_left_q <= in_map && in_l && (eff_l == MARK_OPEN);
			open_down_q <= in_map && in_d && (eff_d == MARK_OPEN);
			open_up_q <= in_map && in_u && (eff_u == MARK_OPEN);
			cell_visited_q <= in_map && (upd || vis_q);
			at_goal_q <= in_map && goal;
		end
	end

	assign sts.clr_last = clr_q == AW'(CELLS - 1);
	assign sts.out_free = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign open_right = open_right_q;
	assign open_left = open_left_q;
	assign open_down = open_down_q;
	assign open_up = open_up_q;
	assign cell_visited = cell_visited_q;
	assign at_goal = at_goal_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> !result_valid_q || result_ready)
		else $error("pending result word overwritten");

	a_visit_once_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		vis_we && !cmd.clear |-> cmd.wr0 && !req_q)
		else $error("visited mark written outside update step");

	a_open_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> !(open_left_q && $past(col_q) == 3'd0))
		else $error("left passage reported across border");

endmodule

FILE: hw/rtl/maze_wall_map_core.sv
// ----------------------------------------------------------------------------
// maze_wall_map_core
// wall map of a square maze: visited marks, inner wall marks, neighbor report
//
//  channel   direction  handshake                     word
//  item      in         item_valid / item_ready       req_type row col heading walls_seen
//  result    out        result_valid / result_ready   open_* cell_visited at_goal
//
//  one item at a time: accept, two reads, two writes and the result step, set by
//  one read and one write port per map memory
//  after reset a clearing pass over all MAZE_DIM*MAZE_DIM cells runs, item_ready low
//  the result register holds one word; a stalled result holds the block in its
//  last step, and the next item can be taken while the word waits
// ----------------------------------------------------------------------------
module maze_wall_map_core
	import mwm_pkg::*;
#(
	parameter int MAZE_DIM = MAZE_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       req_type,
	input  logic [2:0] row,
	input  logic [2:0] col,
	input  logic [1:0] heading,
	input  logic [2:0] walls_seen,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       open_right,
	output logic       open_left,
	output logic       open_down,
	output logic       open_up,
	output logic       cell_visited,
	output logic       at_goal
);

	mwm_cmd_t cmd;
	mwm_sts_t sts;

	mwm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	mwm_dp #(
		.MAZE_DIM (MAZE_DIM)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.row          (row),
		.col          (col),
		.heading      (heading),
		.walls_seen   (walls_seen),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.open_right   (open_right),
		.open_left    (open_left),
		.open_down    (open_down),
		.open_up      (open_up),
		.cell_visited (cell_visited),
		.at_goal      (at_goal)
	);

endmodule
